FILE: rtl/bal_pkg.sv
// Shared types and constants for the buddy allocator with leases.
// Holds the command and response structs, opcodes, status codes and tree node flags.
// No dependencies.
package bal_pkg;

  // Command opcodes.
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_GET     = 2'd1;
  localparam logic [1:0] OP_CHECK   = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  // Response status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;

  // Tree node flags: bit 1 is split, bit 0 is allocated.
  localparam int         FLAG_SPLIT = 1;
  localparam int         FLAG_ALLOC = 0;
  localparam logic [1:0] NODE_FREE  = 2'b00;
  localparam logic [1:0] NODE_SPLIT = 2'b10;
  localparam logic [1:0] NODE_ALLOC = 2'b01;

  // Largest block exponent a request can round up to.
  localparam int K_CAP = 24;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [16:0] req_size;
    logic [15:0] lease_duration;
    logic [5:0]  lease_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  granted_id;
    logic [15:0] block_offset;
    logic [16:0] stored_size;
    logic [6:0]  freed_count;
  } rsp_t;

endpackage

FILE: rtl/buddy_allocator_with_leases.sv
// Top level of the buddy allocator with leases: command sequencer and lease valid bits.
// Depends on bal_pkg, bal_tree_mem and bal_lease_mem.
//
// Usage: a command is taken when start is high and busy is low; exactly one response
// follows, shown on rsp for one cycle with done high, and it cannot be held off. After
// reset and after every pool_log2 write the block clears its node memory, one node per
// cycle, over 2^(POOL_LOG2_MAX-MIN_BLOCK_LOG2+1) nodes (4096 by default), busy high.
// A get or check of a missing lease answers in the cycle after it is taken; otherwise
// it passes through S_GET_EVAL first. A request first scans the valid bits for a free
// slot, one slot a cycle, then walks the node memory depth first, reading each node
// visited through S_TREE_RD and S_TREE_EVAL, with S_TREE_BACK for each step back up or
// across to a right sibling. A tick visits every slot, a live one also in S_TICK_EVAL,
// and checks each buddy in S_REL_RD and S_REL_EVAL while a freed lease merges upward.
// Writes of pool_log2 are accepted in any cycle and are meant for an idle block.
module buddy_allocator_with_leases #(
  parameter int POOL_LOG2_MAX  = 16,
  parameter int MIN_BLOCK_LOG2 = 5,
  parameter int LEASE_SLOTS    = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bal_pkg::cmd_t cmd,
  output logic          done,
  output bal_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_data
);

  import bal_pkg::*;

  localparam int TREE_LEVELS = POOL_LOG2_MAX - MIN_BLOCK_LOG2 + 1;
  localparam int NODE_W      = TREE_LEVELS;
  localparam int LVL_W       = $clog2(TREE_LEVELS + 1);
  localparam int SLOT_W      = $clog2(LEASE_SLOTS);
  localparam int CNT_W       = $clog2(LEASE_SLOTS + 1);
  localparam int OFS_W       = POOL_LOG2_MAX + 1;
  localparam int LEASE_W     = NODE_W + 17 + 32;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_REQ_SCAN, S_TREE_RD, S_TREE_EVAL, S_TREE_BACK,
    S_GET_EVAL, S_TICK_SCAN, S_TICK_EVAL, S_REL_RD, S_REL_EVAL
  } state_t;

  state_t                   state;
  cmd_t                     cmd_q;
  logic [4:0]               pool_log2;
  logic [4:0]               k;
  logic [NODE_W-1:0]        node;
  logic [LVL_W-1:0]         lvl;
  logic [LVL_W-1:0]         target;
  logic [SLOT_W-1:0]        idx;
  logic [CNT_W-1:0]         freed;
  logic [NODE_W-1:0]        clr_addr;
  logic [31:0]              tick_now;
  logic [LEASE_SLOTS-1:0]   valid;

  logic                     tree_we;
  logic [NODE_W-1:0]        tree_waddr;
  logic [1:0]               tree_wdata;
  logic [NODE_W-1:0]        tree_raddr;
  logic [1:0]               tree_rdata;
  logic                     lease_we;
  logic [LEASE_W-1:0]       lease_wdata;
  logic [SLOT_W-1:0]        lease_raddr;
  logic [LEASE_W-1:0]       lease_rdata;

  logic [4:0]               k_calc;
  logic [4:0]               cfg_clamped;
  logic                     id_in_range;
  logic                     idx_last;
  logic [NODE_W-1:0]        rd_node;
  logic [16:0]              rd_bytes;
  logic [31:0]              rd_expiry;
  logic [31:0]              age;
  logic                     expired;
  logic [CNT_W-1:0]         freed_inc;
  logic                     grant;
  logic [NODE_W-1:0]        ofs_node;
  logic [LVL_W-1:0]         ofs_lvl;
  logic [OFS_W-1:0]         ofs_wide;
  logic [15:0]              ofs;

  assign busy = (state != S_IDLE);

  // Round the requested size up to a block exponent, at least the minimum block.
  always_comb begin
    k_calc = 5'(MIN_BLOCK_LOG2);
    for (int j = MIN_BLOCK_LOG2; j < K_CAP; j++) begin
      if ({8'd0, cmd.req_size} > (25'd1 << j)) begin
        k_calc = 5'(j + 1);
      end
    end
  end

  // Saturate a written pool size to the supported range.
  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data < 5'(MIN_BLOCK_LOG2)) begin
      cfg_clamped = 5'(MIN_BLOCK_LOG2);
    end else if (cfg_data > 5'(POOL_LOG2_MAX)) begin
      cfg_clamped = 5'(POOL_LOG2_MAX);
    end
  end

  assign id_in_range = (32'(cmd.lease_id) < LEASE_SLOTS);
  assign idx_last    = (idx == SLOT_W'(LEASE_SLOTS - 1));

  // Lease table entry fields and the serial expiry compare.
  assign rd_node   = lease_rdata[LEASE_W-1 -: NODE_W];
  assign rd_bytes  = lease_rdata[48:32];
  assign rd_expiry = lease_rdata[31:0];
  assign age       = tick_now - rd_expiry - 32'd1;
  assign expired   = !age[31];
  assign freed_inc = freed + CNT_W'(expired);

  // A free, unsplit node at the target level ends the search with a grant.
  assign grant = (state == S_TREE_EVAL) && (tree_rdata == NODE_FREE) && (lvl == target);

  // Byte offset of a node: its index within its level, scaled by the block size.
  always_comb begin
    ofs_node = (state == S_GET_EVAL) ? rd_node : node;
    ofs_lvl  = '0;
    for (int j = 0; j < NODE_W; j++) begin
      if (ofs_node[j]) begin
        ofs_lvl = LVL_W'(j);
      end
    end
    ofs_wide = OFS_W'(ofs_node) << (pool_log2 - 5'(ofs_lvl));
    ofs_wide = ofs_wide & ~(OFS_W'(1) << pool_log2);
    ofs      = 16'(ofs_wide);
  end

  // Memory port control.
  always_comb begin
    tree_we     = 1'b0;
    tree_waddr  = node;
    tree_wdata  = NODE_FREE;
    tree_raddr  = node;
    lease_we    = grant;
    lease_wdata = {node, cmd_q.req_size, tick_now + 32'(cmd_q.lease_duration)};
    lease_raddr = idx;
    case (state)
      S_IDLE: begin
        lease_raddr = SLOT_W'(cmd.lease_id);
      end
      S_CLEAR: begin
        tree_we    = 1'b1;
        tree_waddr = clr_addr;
      end
      S_TREE_EVAL: begin
        if (tree_rdata == NODE_FREE) begin
          tree_we    = 1'b1;
          tree_wdata = (lvl == target) ? NODE_ALLOC : NODE_SPLIT;
        end
      end
      S_TICK_EVAL: begin
        if (expired) begin
          tree_we    = 1'b1;
          tree_waddr = rd_node;
        end
      end
      S_REL_RD: begin
        tree_raddr = node ^ NODE_W'(1);
      end
      S_REL_EVAL: begin
        if (tree_rdata == NODE_FREE) begin
          tree_we    = 1'b1;
          tree_waddr = node >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  bal_tree_mem #(
    .ADDR_W (NODE_W)
  ) u_tree (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tree_rdata)
  );

  bal_lease_mem #(
    .DEPTH  (LEASE_SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (LEASE_W)
  ) u_lease (
    .clk   (clk),
    .we    (lease_we),
    .waddr (idx),
    .wdata (lease_wdata),
    .raddr (lease_raddr),
    .rdata (lease_rdata)
  );

  // Command sequencer, lease valid bits and the registered response.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      tick_now  <= '0;
      pool_log2 <= 5'(POOL_LOG2_MAX);
      valid     <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            k     <= k_calc;
            idx   <= '0;
            freed <= '0;
            case (cmd.opcode)
              OP_REQUEST: begin
                state <= S_REQ_SCAN;
              end
              OP_TICK: begin
                tick_now <= tick_now + 32'd1;
                state    <= S_TICK_SCAN;
              end
              default: begin
                if (!id_in_range || !valid[SLOT_W'(cmd.lease_id)]) begin
                  done       <= 1'b1;
                  rsp        <= '0;
                  rsp.status <= ST_NOTFOUND;
                end else begin
                  state <= S_GET_EVAL;
                end
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + NODE_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_REQ_SCAN: begin
          if (!valid[idx]) begin
            if (k > pool_log2) begin
              done       <= 1'b1;
              rsp        <= '0;
              rsp.status <= ST_NO_SPACE;
              state      <= S_IDLE;
            end else begin
              node   <= NODE_W'(1);
              lvl    <= '0;
              target <= LVL_W'(pool_log2 - k);
              state  <= S_TREE_RD;
            end
          end else if (idx_last) begin
            done       <= 1'b1;
            rsp        <= '0;
            rsp.status <= ST_FULL;
            state      <= S_IDLE;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end
        S_TREE_RD: begin
          state <= S_TREE_EVAL;
        end
        S_TREE_EVAL: begin
          if (tree_rdata[FLAG_ALLOC]) begin
            state <= S_TREE_BACK;
          end else if (lvl == target) begin
            if (tree_rdata[FLAG_SPLIT]) begin
              state <= S_TREE_BACK;
            end else begin
              valid[idx]       <= 1'b1;
              done             <= 1'b1;
              rsp              <= '0;
              rsp.status       <= ST_OK;
              rsp.granted_id   <= 6'(idx);
              rsp.block_offset <= ofs;
              rsp.stored_size  <= cmd_q.req_size;
              state            <= S_IDLE;
            end
          end else begin
            node  <= node << 1;
            lvl   <= lvl + LVL_W'(1);
            state <= S_TREE_RD;
          end
        end
        S_TREE_BACK: begin
          if (node == NODE_W'(1)) begin
            done       <= 1'b1;
            rsp        <= '0;
            rsp.status <= ST_NO_SPACE;
            state      <= S_IDLE;
          end else if (!node[0]) begin
            node  <= node + NODE_W'(1);
            state <= S_TREE_RD;
          end else begin
            node <= node >> 1;
            lvl  <= lvl - LVL_W'(1);
          end
        end
        S_GET_EVAL: begin
          done <= 1'b1;
          rsp  <= '0;
          if (cmd_q.opcode == OP_GET) begin
            rsp.status       <= ST_OK;
            rsp.block_offset <= ofs;
            rsp.stored_size  <= rd_bytes;
          end else begin
            rsp.status <= (rd_bytes != cmd_q.req_size) ? ST_MISMATCH : ST_OK;
          end
          state <= S_IDLE;
        end
        S_TICK_SCAN: begin
          if (valid[idx]) begin
            state <= S_TICK_EVAL;
          end else if (idx_last) begin
            done            <= 1'b1;
            rsp             <= '0;
            rsp.freed_count <= 7'(freed);
            state           <= S_IDLE;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end
        S_TICK_EVAL: begin
          freed <= freed_inc;
          node  <= rd_node;
          if (expired) begin
            valid[idx] <= 1'b0;
          end
          if (expired && rd_node != NODE_W'(1)) begin
            state <= S_REL_RD;
          end else if (idx_last) begin
            done            <= 1'b1;
            rsp             <= '0;
            rsp.freed_count <= 7'(freed_inc);
            state           <= S_IDLE;
          end else begin
            idx   <= idx + SLOT_W'(1);
            state <= S_TICK_SCAN;
          end
        end
        S_REL_RD: begin
          state <= S_REL_EVAL;
        end
        S_REL_EVAL: begin
          // Merge upward while the buddy is free as well.
          if (tree_rdata == NODE_FREE && (node >> 1) != NODE_W'(1)) begin
            node  <= node >> 1;
            state <= S_REL_RD;
          end else if (idx_last) begin
            done            <= 1'b1;
            rsp             <= '0;
            rsp.freed_count <= 7'(freed);
            state           <= S_IDLE;
          end else begin
            idx   <= idx + SLOT_W'(1);
            state <= S_TICK_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // A pool size write restarts the pool and drops every lease.
      if (cfg_we) begin
        pool_log2 <= cfg_clamped;
        valid     <= '0;
        clr_addr  <= '0;
        state     <= S_CLEAR;
      end
    end
  end

  // A taken command either answers at once or keeps the block busy.
  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("taken command neither answered nor held busy");

  // The search never descends below the target level.
  a_search_depth: assert property (@(posedge clk) disable iff (rst)
    state == S_TREE_EVAL |-> lvl <= target)
    else $error("tree search went below target level");

  // A response never comes out of the clearing pass.
  a_no_done_from_clear: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_CLEAR)
    else $error("response during clearing pass");

  // Failed commands report no block.
  a_fail_no_block: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.block_offset == '0 && rsp.stored_size == '0)
    else $error("failed command reported a block");

endmodule

FILE: rtl/bal_tree_mem.sv
// Buddy tree flag memory: one two-bit entry per tree node.
// Synchronous write and registered read.
// No dependencies.
module bal_tree_mem #(
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [1:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [1:0]        rdata
);

  logic [1:0] mem [2**ADDR_W];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bal_lease_mem.sv
// Lease table memory: block node, stored size and expiry tick for each slot.
// Synchronous write and registered read.
// No dependencies.
module bal_lease_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 61
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for buddy_allocator_with_leases: a directed table, then random phases.
// Commands are checked against an in-bench model of the buddy tree and lease table.
// Depends on bal_pkg and the buddy_allocator_with_leases RTL.
`timescale 1ns / 1ps

module testbench;
  import bal_pkg::*;

  localparam int POOL_MAX   = 16;
  localparam int MIN_LOG2   = 5;
  localparam int SLOTS      = 64;
  localparam int NODES      = 1 << (POOL_MAX - MIN_LOG2 + 1);
  localparam int CYCLE_CAP  = 100_000_000;
  localparam int PHASE_LEN  = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;

  buddy_allocator_with_leases dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Allocator model state.
  bit          node_split [NODES];
  bit          node_taken [NODES];
  bit          slot_live [SLOTS];
  int          slot_node [SLOTS];
  logic [16:0] slot_bytes [SLOTS];
  logic [31:0] slot_expiry [SLOTS];
  logic [31:0] ticks;
  int          pool_lg;

  rsp_t pending_rsp [$];
  int   failures = 0;
  longint cycles = 0;
  bit   idle_gaps = 1'b1;

  typedef struct {
    cmd_t c;
    bit   typed;
    rsp_t r;
  } row_t;
  row_t directed [$];

  function automatic void wipe_pool();
    for (int n = 0; n < NODES; n++) begin
      node_split[n] = 0;
      node_taken[n] = 0;
    end
    for (int s = 0; s < SLOTS; s++) slot_live[s] = 0;
  endfunction

  // Left-first depth-first search for a free block at the target level.
  function automatic int grab_block(int node, int lvl, int target);
    int got;
    if (node == 0 || node >= NODES || lvl > target) return 0;
    if (node_taken[node]) return 0;
    if (node_split[node]) begin
      got = grab_block(2 * node, lvl + 1, target);
      if (got != 0) return got;
      return grab_block(2 * node + 1, lvl + 1, target);
    end
    if (lvl == target) begin
      node_taken[node] = 1;
      return node;
    end
    node_split[node] = 1;
    return grab_block(2 * node, lvl + 1, target);
  endfunction

  function automatic logic [15:0] block_addr(int node);
    int lvl;
    longint off;
    lvl = 0;
    while ((node >> (lvl + 1)) != 0) lvl++;
    if (lvl > pool_lg) return '0;
    off = longint'(node - (1 << lvl)) << (pool_lg - lvl);
    return off[15:0];
  endfunction

  // Free a block and merge free buddy pairs upward.
  function automatic void free_block(int node);
    int p;
    node_taken[node] = 0;
    while (node > 1) begin
      p = node >> 1;
      if (node_taken[2*p] || node_split[2*p] || node_taken[2*p+1] || node_split[2*p+1]) break;
      node_split[p] = 0;
      node_taken[p] = 0;
      node = p;
    end
  endfunction

  // Apply one command to the model and return the response it must produce.
  function automatic rsp_t alloc_predict(cmd_t c);
    rsp_t r;
    int k, slot, node;
    r = '0;
    case (c.opcode)
      OP_REQUEST: begin
        k = MIN_LOG2;
        while (k < K_CAP && (32'd1 << k) < c.req_size) k++;
        slot = SLOTS;
        for (int s = SLOTS - 1; s >= 0; s--) if (!slot_live[s]) slot = s;
        if (slot == SLOTS) r.status = ST_FULL;
        else if (k > pool_lg) r.status = ST_NO_SPACE;
        else begin
          node = grab_block(1, 0, pool_lg - k);
          if (node == 0) r.status = ST_NO_SPACE;
          else begin
            slot_live[slot] = 1;
            slot_node[slot] = node;
            slot_bytes[slot] = c.req_size;
            slot_expiry[slot] = ticks + 32'(c.lease_duration);
            r.granted_id = slot[5:0];
            r.block_offset = block_addr(node);
            r.stored_size = c.req_size;
          end
        end
      end
      OP_GET, OP_CHECK: begin
        if (!slot_live[c.lease_id]) r.status = ST_NOTFOUND;
        else if (c.opcode == OP_GET) begin
          r.block_offset = block_addr(slot_node[c.lease_id]);
          r.stored_size = slot_bytes[c.lease_id];
        end else if (slot_bytes[c.lease_id] != c.req_size) r.status = ST_MISMATCH;
      end
      default: begin
        ticks = ticks + 1;
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_live[s] && (ticks - slot_expiry[s] - 32'd1) < 32'h8000_0000) begin
            free_block(slot_node[s]);
            slot_live[s] = 0;
            r.freed_count = r.freed_count + 1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Present one transaction, wait for acceptance, record the expected response.
  task automatic issue(cmd_t c, bit typed, rsp_t want);
    rsp_t pred;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!(start && !busy));
    pred = alloc_predict(c);
    pending_rsp = {pending_rsp, (typed ? want : pred)};
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      cmd <= cmd_t'({$urandom, $urandom});
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Reconfigure the pool once the block has drained.
  task automatic write_pool(logic [4:0] v);
    start <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_lg = (v < MIN_LOG2) ? MIN_LOG2 : (v > POOL_MAX) ? POOL_MAX : v;
    wipe_pool();
    repeat (4) @(posedge clk);
  endtask

  function automatic void add_row(logic [1:0] op, int sz, int dur, int id, bit typed,
                                  logic [2:0] st, int gid, int off, int ssz, int fc);
    row_t w;
    w.c = '{opcode: op, req_size: sz, lease_duration: dur, lease_id: id};
    w.typed = typed;
    w.r = '{status: st, granted_id: gid, block_offset: off, stored_size: ssz,
            freed_count: fc};
    directed = {directed, w};
  endfunction

  // Random command, mostly well-formed for the current pool and live leases.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    c = cmd_t'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.opcode = OP_REQUEST;
      if ($urandom_range(0, 9) != 0) c.req_size = $urandom_range(0, (1 << pool_lg) / 4);
      if ($urandom_range(0, 9) != 0) c.lease_duration = $urandom_range(0, 20);
    end else if (pick < 70) begin
      c.opcode = ($urandom_range(0, 1) == 0) ? OP_GET : OP_CHECK;
      if ($urandom_range(0, 4) != 0) c.lease_id = $urandom_range(0, 15);
      if (c.opcode == OP_CHECK && slot_live[c.lease_id] && $urandom_range(0, 1) == 0)
        c.req_size = slot_bytes[c.lease_id];
    end else c.opcode = OP_TICK;
    return c;
  endfunction

  // Response checker: each strobe is compared with the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response %h", rsp);
        failures++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          failures++;
        end
        if (rsp.granted_id !== want.granted_id) begin
          $error("granted_id: expected %0d, got %0d", want.granted_id, rsp.granted_id);
          failures++;
        end
        if (rsp.block_offset !== want.block_offset) begin
          $error("block_offset: expected %0d, got %0d", want.block_offset, rsp.block_offset);
          failures++;
        end
        if (rsp.stored_size !== want.stored_size) begin
          $error("stored_size: expected %0d, got %0d", want.stored_size, rsp.stored_size);
          failures++;
        end
        if (rsp.freed_count !== want.freed_count) begin
          $error("freed_count: expected %0d, got %0d", want.freed_count, rsp.freed_count);
          failures++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("[buddy_allocator_with_leases] ERROR");
      $finish;
    end
  end

  initial begin
    int cfg_list [13] = '{10, 5, 0, 31, 7, 16, 6, 12, 3, 8, 30, 9, 11};
    int waited;
    ticks = '0;
    pool_lg = POOL_MAX;
    wipe_pool();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at the reset pool size.
    add_row(OP_GET,     0,      0,     0,  1, ST_NOTFOUND, 0, 0, 0, 0);
    add_row(OP_CHECK,   131071, 65535, 63, 1, ST_NOTFOUND, 0, 0, 0, 0);
    add_row(OP_TICK,    0,      0,     0,  1, ST_OK,       0, 0, 0, 0);
    add_row(OP_REQUEST, 0,      0,     0,  1, ST_OK,       0, 0, 0, 0);
    add_row(OP_REQUEST, 131071, 65535, 0,  1, ST_NO_SPACE, 0, 0, 0, 0);
    add_row(OP_REQUEST, 65536,  0,     0,  1, ST_NO_SPACE, 0, 0, 0, 0);
    add_row(OP_REQUEST, 33,     65535, 63, 0, ST_OK,       0, 0, 0, 0);
    add_row(OP_REQUEST, 65535,  1,     0,  0, ST_OK,       0, 0, 0, 0);
    add_row(OP_REQUEST, 32768,  5,     0,  0, ST_OK,       0, 0, 0, 0);
    add_row(OP_GET,     0,      0,     0,  0, ST_OK,       0, 0, 0, 0);
    add_row(OP_GET,     0,      0,     1,  0, ST_OK,       0, 0, 0, 0);
    add_row(OP_CHECK,   0,      0,     0,  1, ST_OK,       0, 0, 0, 0);
    add_row(OP_CHECK,   1,      0,     0,  1, ST_MISMATCH, 0, 0, 0, 0);
    add_row(OP_CHECK,   34,     0,     1,  1, ST_MISMATCH, 0, 0, 0, 0);
    add_row(OP_GET,     0,      0,     5,  1, ST_NOTFOUND, 0, 0, 0, 0);
    add_row(OP_TICK,    0,      0,     0,  0, ST_OK,       0, 0, 0, 0);
    add_row(OP_GET,     0,      0,     0,  1, ST_NOTFOUND, 0, 0, 0, 0);
    add_row(OP_REQUEST, 1,      3,     0,  0, ST_OK,       0, 0, 0, 0);
    add_row(OP_REQUEST, 65535,  65535, 0,  0, ST_OK,       0, 0, 0, 0);
    foreach (directed[i]) issue(directed[i].c, directed[i].typed, directed[i].r);

    // Random phases, each after a pool size write.
    foreach (cfg_list[p]) begin
      write_pool(5'(cfg_list[p]));
      idle_gaps = (p < 11);
      if (pool_lg == POOL_MAX && cfg_list[p] == 31) begin
        // Fill the lease table with long leases, past the point of table full.
        repeat (70) issue('{opcode: OP_REQUEST, req_size: $urandom_range(0, 64),
                           lease_duration: $urandom_range(60000, 65535),
                           lease_id: $urandom}, 1'b0, '0);
      end
      repeat (PHASE_LEN) issue(random_cmd(), 1'b0, '0);
    end

    start <= 1'b0;
    wait (pending_rsp.size() == 0);
    waited = 0;
    while (waited < 200) begin
      @(posedge clk);
      waited++;
    end
    if (failures == 0 && pending_rsp.size() == 0) begin
      $display("[buddy_allocator_with_leases] OK");
    end else begin
      $display("[buddy_allocator_with_leases] ERROR");
    end
    $finish;
  end

endmodule
